// ===== rtl/rcs_pkg.sv =====
// Shared widths and derived constants for the raycast column setup block.
package rcs_pkg;

  localparam int SCREEN_HEIGHT = 480;
  localparam int TEX_SIZE      = 64;
  localparam int FRAC_BITS     = 16;

  // Field widths
  localparam int DIST_W = 32;
  localparam int DIR_W  = 20;
  localparam int LH_W   = 16;
  localparam int ROW_W  = 9;
  localparam int TEX_W  = 6;

  // Wall coordinate keeps 2*FRAC_BITS fraction bits
  localparam int WALL_W = 2 * FRAC_BITS;

  // Height divider
  localparam logic [63:0] DIVIDEND = 64'(SCREEN_HEIGHT) << FRAC_BITS;
  localparam int          DVD_W    = $clog2(DIVIDEND + 64'd1);
  localparam int          SHIFT_W  = DIST_W + LH_W;
  // Quotient exceeds the height range exactly when perp_dist is at most this
  localparam logic [63:0] SAT_LIM  = DIVIDEND >> LH_W;
  localparam int          DIV_BITS = 2;
  localparam int          DIV_STG  = LH_W / DIV_BITS;

  // Row arithmetic
  localparam int RSUM_W   = LH_W + 1;
  localparam int HALF_ROW = SCREEN_HEIGHT / 2;
  localparam int LAST_ROW = SCREEN_HEIGHT - 1;

  // Texture index
  localparam int TIX_W   = (TEX_SIZE > 2) ? $clog2(TEX_SIZE) : 1;
  localparam int TPROD_W = WALL_W + $clog2(TEX_SIZE) + 1;

  localparam logic [LH_W-1:0] LH_MAX = '1;

endpackage

// ===== rtl/rcs_if.sv =====
// Valid/ready channel interfaces for column items and column results.
interface rcs_in_if import rcs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit_side;
  logic [DIST_W-1:0]       side_dist_x;
  logic [DIST_W-1:0]       side_dist_y;
  logic [DIST_W-1:0]       delta_dist_x;
  logic [DIST_W-1:0]       delta_dist_y;
  logic [DIST_W-1:0]       pos_x;
  logic [DIST_W-1:0]       pos_y;
  logic signed [DIR_W-1:0] ray_dir_x;
  logic signed [DIR_W-1:0] ray_dir_y;

  modport source (
    output valid, hit_side, side_dist_x, side_dist_y, delta_dist_x, delta_dist_y,
           pos_x, pos_y, ray_dir_x, ray_dir_y,
    input  ready
  );
  modport sink (
    input  valid, hit_side, side_dist_x, side_dist_y, delta_dist_x, delta_dist_y,
           pos_x, pos_y, ray_dir_x, ray_dir_y,
    output ready
  );
endinterface

interface rcs_out_if import rcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] perp_dist;
  logic [LH_W-1:0]   line_height;
  logic [ROW_W-1:0]  draw_start;
  logic [ROW_W-1:0]  draw_end;
  logic [TEX_W-1:0]  tex_column;

  modport source (
    output valid, perp_dist, line_height, draw_start, draw_end, tex_column,
    input  ready
  );
  modport sink (
    input  valid, perp_dist, line_height, draw_start, draw_end, tex_column,
    output ready
  );
endinterface

// ===== rtl/raycast_column_setup_top.sv =====
// Wall column projection: perpendicular distance, line height, draw rows, texture column.
//
//   channel | dir | transaction
//   --------+-----+------------------------------------------------------------
//   in_i    | in  | hit side, side/delta distances, position, ray direction
//   out_o   | out | perp_dist, line_height, draw_start, draw_end, tex_column
//
// One column enters per cycle unless every stage holds a column and the output stalls;
// each result passes through 11 register stages: the radix-4 height divider
// (8 stages of 2 quotient bits) plus the distance, multiply and row stages around it.
// Every stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up behind a stalled output.
// Reset clears the valid bits only.
module raycast_column_setup_top import rcs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  rcs_in_if.sink     in_i,
  rcs_out_if.source  out_o
);

  localparam int NSTG = DIV_STG + 3;

  typedef struct packed {
    logic [DIST_W-1:0]       perp;
    logic signed [DIR_W-1:0] dir;
    logic [FRAC_BITS-1:0]    pos_lo;
    logic                    mirror;
    logic [WALL_W-1:0]       prod;
    logic                    sat;
    logic [DVD_W-1:0]        rem;
    logic [LH_W-1:0]         quo;
    logic [TIX_W-1:0]        tex;
    logic [ROW_W-1:0]        row_start;
    logic [ROW_W-1:0]        row_end;
  } stage_t;

  stage_t            stg_q [NSTG];
  stage_t            stg_d [NSTG];
  logic [NSTG-1:0]   vld_q;
  logic [NSTG-1:0]   vld_in;
  logic [NSTG:0]     rdy;

  // Valid bit offered to each stage by its predecessor
  assign vld_in = {vld_q[NSTG-2:0], in_i.valid};

  // Stage k moves when empty or when stage k+1 moves
  always_comb begin
    rdy[NSTG] = out_o.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_i.ready = rdy[0];

  always_comb begin
    logic [DIST_W-1:0]  sd;
    logic [DIST_W-1:0]  dd;
    logic               pos_dir;
    logic [WALL_W-1:0]  mul_a;
    logic [WALL_W-1:0]  mul_b;
    logic [WALL_W-1:0]  wall;
    logic [TPROD_W-1:0] tprod;
    logic [TIX_W-1:0]   tix;
    logic [SHIFT_W-1:0] dsh;
    logic [LH_W-1:0]    lh;
    logic [LH_W-2:0]    hl;
    logic [RSUM_W-1:0]  rsum;
    int                 bitpos;

    // Stage 0: perpendicular distance and per-side selection
    stg_d[0] = stg_q[0];
    sd = in_i.hit_side ? in_i.side_dist_y : in_i.side_dist_x;
    dd = in_i.hit_side ? in_i.delta_dist_y : in_i.delta_dist_x;
    stg_d[0].perp   = (sd >= dd) ? (sd - dd) : '0;
    stg_d[0].dir    = in_i.hit_side ? in_i.ray_dir_x : in_i.ray_dir_y;
    stg_d[0].pos_lo = in_i.hit_side ? in_i.pos_x[FRAC_BITS-1:0]
                                    : in_i.pos_y[FRAC_BITS-1:0];
    pos_dir = !in_i.ray_dir_x[DIR_W-1] && (in_i.ray_dir_x != '0);
    stg_d[0].mirror = in_i.hit_side ? in_i.ray_dir_y[DIR_W-1] : pos_dir;

    for (int k = 1; k < NSTG; k++) begin
      stg_d[k] = stg_q[k-1];

      // Stage 1: wall offset product, saturation check, divider seed
      if (k == 1) begin
        mul_a = WALL_W'(stg_q[0].perp);
        mul_b = WALL_W'(stg_q[0].dir);
        stg_d[k].prod = mul_a * mul_b;
        stg_d[k].sat  = (stg_q[0].perp <= DIST_W'(SAT_LIM));
        stg_d[k].rem  = DVD_W'(DIVIDEND);
        stg_d[k].quo  = '0;
      end

      // Texture column from the wall fraction
      if (k == 2) begin
        wall  = {stg_q[1].pos_lo, {FRAC_BITS{1'b0}}} + stg_q[1].prod;
        tprod = TPROD_W'(wall) * TPROD_W'(TEX_SIZE);
        tix   = TIX_W'(tprod >> WALL_W);
        stg_d[k].tex = stg_q[1].mirror ? (TIX_W'(TEX_SIZE - 1) - tix) : tix;
      end

      // Restoring division, DIV_BITS quotient bits per stage, MSB first
      if (k >= 2 && k <= DIV_STG + 1) begin
        for (int b = 0; b < DIV_BITS; b++) begin
          bitpos = LH_W - 1 - (k - 2) * DIV_BITS - b;
          dsh = SHIFT_W'(stg_d[k].perp) << bitpos;
          if (SHIFT_W'(stg_d[k].rem) >= dsh) begin
            stg_d[k].rem = stg_d[k].rem - DVD_W'(dsh);
            stg_d[k].quo = {stg_d[k].quo[LH_W-2:0], 1'b1};
          end else begin
            stg_d[k].quo = {stg_d[k].quo[LH_W-2:0], 1'b0};
          end
        end
      end

      // Final stage: saturate height, clamp rows
      if (k == NSTG - 1) begin
        lh = stg_q[k-1].sat ? LH_MAX : stg_q[k-1].quo;
        hl = lh[LH_W-1:1];
        stg_d[k].quo = lh;
        if (RSUM_W'(hl) >= RSUM_W'(HALF_ROW)) begin
          stg_d[k].row_start = '0;
        end else begin
          stg_d[k].row_start = ROW_W'(RSUM_W'(HALF_ROW) - RSUM_W'(hl));
        end
        rsum = RSUM_W'(HALF_ROW) + RSUM_W'(hl);
        if (rsum >= RSUM_W'(SCREEN_HEIGHT)) begin
          stg_d[k].row_end = ROW_W'(LAST_ROW);
        end else begin
          stg_d[k].row_end = ROW_W'(rsum);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // Payload registers load only with a live transaction
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k] && vld_in[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign out_o.valid       = vld_q[NSTG-1];
  assign out_o.perp_dist   = stg_q[NSTG-1].perp;
  assign out_o.line_height = stg_q[NSTG-1].quo;
  assign out_o.draw_start  = stg_q[NSTG-1].row_start;
  assign out_o.draw_end    = stg_q[NSTG-1].row_end;
  assign out_o.tex_column  = TEX_W'(stg_q[NSTG-1].tex);

`ifndef ASSERT_OFF
  // Input may only stall when every stage holds a transaction
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  a_near_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.perp_dist <= DIST_W'(SAT_LIM)) |->
      (out_o.line_height == LH_MAX))
    else $error("line height not saturated for a near wall");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.draw_start <= out_o.draw_end))
    else $error("draw_start beyond draw_end");

  a_full_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.line_height == LH_MAX) |->
      (out_o.draw_start == '0) && (out_o.draw_end == ROW_W'(LAST_ROW)))
    else $error("saturated height does not span the screen");
`endif

endmodule

// ===== tb/sv/tb_raycast_column_setup_top.sv =====
// Self-checking testbench for the raycast column setup block.
module tb_raycast_column_setup_top import rcs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              hit_side;
    logic [DIST_W-1:0] side_dist_x;
    logic [DIST_W-1:0] side_dist_y;
    logic [DIST_W-1:0] delta_dist_x;
    logic [DIST_W-1:0] delta_dist_y;
    logic [DIST_W-1:0] pos_x;
    logic [DIST_W-1:0] pos_y;
    logic [DIR_W-1:0]  ray_dir_x;
    logic [DIR_W-1:0]  ray_dir_y;
  } column_t;

  typedef struct packed {
    logic [DIST_W-1:0] perp_dist;
    logic [LH_W-1:0]   line_height;
    logic [ROW_W-1:0]  draw_start;
    logic [ROW_W-1:0]  draw_end;
    logic [TEX_W-1:0]  tex_column;
  } wall_slice_t;

  // typed = 1 means slice holds the hand-computed result for this column
  typedef struct packed {
    column_t     col;
    logic        typed;
    wall_slice_t slice;
  } column_job_t;

  localparam int          RANDOM_COLS = 1700;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          N_DIRECTED  = 20;
  localparam logic [31:0] ONE         = 32'h0001_0000;

  // Zero or negative distance: full-height slice
  localparam wall_slice_t AT_WALL = '{32'd0, 16'hFFFF, 9'd0, 9'd479, 6'd0};
  localparam wall_slice_t NONE    = '0;

  localparam column_job_t DIRECTED_JOBS [N_DIRECTED] = '{
    // zero distance, both sides
    '{'{1'b0, 32'h0003_0000, 32'd0, 32'h0003_0000, 32'd0, 32'd0, 32'd0, 20'd0, 20'd0},
      1'b1, AT_WALL},
    '{'{1'b1, 32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0, 20'd0, 20'd0}, 1'b1, AT_WALL},
    // negative distance, both sides
    '{'{1'b0, 32'h0000_8000, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 20'd0, 20'd0}, 1'b1, AT_WALL},
    '{'{1'b1, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 20'd0, 20'd0},
      1'b1, AT_WALL},
    // distance 1.0 and 2.0
    '{'{1'b0, 32'h0002_0000, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 20'd0, 20'd0},
      1'b1, '{ONE, 16'd480, 9'd0, 9'd479, 6'd0}},
    '{'{1'b1, 32'd0, 32'h0003_0000, 32'd0, ONE, 32'd0, 32'd0, 20'd0, 20'd0},
      1'b1, '{32'h0002_0000, 16'd240, 9'd120, 9'd360, 6'd0}},
    // farthest wall
    '{'{1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 20'd0, 20'd0},
      1'b1, '{32'hFFFF_FFFF, 16'd0, 9'd240, 9'd240, 6'd0}},
    // height overflow around the saturation limit
    '{'{1'b0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 20'd0, 20'd0},
      1'b1, '{32'd1, 16'hFFFF, 9'd0, 9'd479, 6'd0}},
    '{'{1'b0, 32'd480, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 20'd0, 20'd0},
      1'b1, '{32'd480, 16'hFFFF, 9'd0, 9'd479, 6'd0}},
    '{'{1'b0, 32'd481, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 20'd0, 20'd0},
      1'b1, '{32'd481, 16'd65399, 9'd0, 9'd479, 6'd0}},
    // mirrored texture on facing sides
    '{'{1'b0, 32'h0002_0000, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 20'd1, 20'd0},
      1'b1, '{ONE, 16'd480, 9'd0, 9'd479, 6'd63}},
    '{'{1'b1, 32'd0, 32'h0002_0000, 32'd0, ONE, 32'd0, 32'd0, 20'd0, 20'hFFFFF},
      1'b1, '{ONE, 16'd480, 9'd0, 9'd479, 6'd63}},
    // negative wall coordinate: fraction taken from the floor
    '{'{1'b0, 32'h0002_0000, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 20'd0, 20'hFFFFF},
      1'b1, '{ONE, 16'd480, 9'd0, 9'd479, 6'd63}},
    // half-way along the wall, no mirror for a leftward ray
    '{'{1'b0, 32'h0002_0000, 32'd0, ONE, 32'd0, 32'd0, 32'h0000_8000, 20'hFFFFF, 20'd0},
      1'b1, '{ONE, 16'd480, 9'd0, 9'd479, 6'd32}},
    // field extremes and wrapping wall coordinates
    '{'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'h7FFFF, 20'h80000}, 1'b0, NONE},
    '{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'h80000, 20'h7FFFF}, 1'b0, NONE},
    '{'{1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 20'h7FFFF, 20'd0},
      1'b0, NONE},
    '{'{1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 20'd0, 20'h80000},
      1'b0, NONE},
    '{'{1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
        32'hAAAA_AAAA, 32'h5555_5555, 20'hAAAAA, 20'h55555}, 1'b0, NONE},
    '{'{1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
        32'h5555_5555, 32'hAAAA_AAAA, 20'h55555, 20'hAAAAA}, 1'b0, NONE}
  };

  logic clk_i;
  logic rst_ni;

  rcs_in_if  col_if ();
  rcs_out_if slice_if ();

  raycast_column_setup_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (col_if),
    .out_o  (slice_if)
  );

  column_job_t col_q [$];
  wall_slice_t slice_q [$];
  column_job_t cur_job;
  int          total_cols;
  int          cols_taken;
  int          mismatches;
  int          cycles;

  function automatic wall_slice_t project_column(column_t c);
    logic [DIST_W-1:0] sd, dd, pos, perp;
    logic [DIR_W-1:0]  dir;
    logic [63:0]       quot, dir_ext, wall, tex_full;
    logic [LH_W-1:0]   lh;
    logic [TEX_W-1:0]  tex;
    int                start_row, end_row;
    wall_slice_t       r;
    sd   = c.hit_side ? c.side_dist_y : c.side_dist_x;
    dd   = c.hit_side ? c.delta_dist_y : c.delta_dist_x;
    pos  = c.hit_side ? c.pos_x : c.pos_y;
    dir  = c.hit_side ? c.ray_dir_x : c.ray_dir_y;
    perp = (sd >= dd) ? sd - dd : '0;
    if (perp == '0) begin
      lh = '1;
    end else begin
      quot = (64'(SCREEN_HEIGHT) << FRAC_BITS) / 64'(perp);
      lh   = (quot > 64'(16'hFFFF)) ? '1 : quot[LH_W-1:0];
    end
    start_row = SCREEN_HEIGHT / 2 - int'(lh >> 1);
    end_row   = SCREEN_HEIGHT / 2 + int'(lh >> 1);
    if (start_row < 0) start_row = 0;
    if (end_row > SCREEN_HEIGHT - 1) end_row = SCREEN_HEIGHT - 1;
    // two's complement product modulo 2^64 leaves the fraction intact
    dir_ext  = {{(64-DIR_W){dir[DIR_W-1]}}, dir};
    wall     = (64'(pos) << FRAC_BITS) + 64'(perp) * dir_ext;
    tex_full = (64'(wall[WALL_W-1:0]) * 64'(TEX_SIZE)) >> WALL_W;
    tex      = tex_full[TEX_W-1:0];
    if ((!c.hit_side && !c.ray_dir_x[DIR_W-1] && c.ray_dir_x != '0) ||
        (c.hit_side && c.ray_dir_y[DIR_W-1]))
      tex = TEX_W'(TEX_SIZE - 1) - tex;
    r.perp_dist   = perp;
    r.line_height = lh;
    r.draw_start  = ROW_W'(start_row);
    r.draw_end    = ROW_W'(end_row);
    r.tex_column  = tex;
    return r;
  endfunction

  function automatic column_t random_column();
    column_t          c;
    logic [DIST_W-1:0] perp, sd, dd;
    c.hit_side     = 1'($urandom_range(1));
    c.side_dist_x  = $urandom;
    c.side_dist_y  = $urandom;
    c.delta_dist_x = $urandom;
    c.delta_dist_y = $urandom;
    c.pos_x        = $urandom;
    c.pos_y        = $urandom;
    c.ray_dir_x    = ($urandom_range(7) == 0) ? '0 : DIR_W'($urandom);
    c.ray_dir_y    = ($urandom_range(7) == 0) ? '0 : DIR_W'($urandom);
    case ($urandom_range(7))
      0:       perp = '0;
      1:       perp = $urandom_range(600, 1);
      2:       perp = $urandom_range(140000, 60000);
      3:       perp = $urandom_range(32'h0040_0000, 600);
      default: perp = $urandom;
    endcase
    if ($urandom_range(9) == 0) begin
      // side distance below the step: distance goes negative
      dd = $urandom | 32'h1;
      sd = $urandom_range(dd - 1, 0);
    end else begin
      dd = $urandom_range(32'hFFFF_FFFF - perp, 0);
      sd = dd + perp;
    end
    if (c.hit_side) begin
      c.side_dist_y  = sd;
      c.delta_dist_y = dd;
    end else begin
      c.side_dist_x  = sd;
      c.delta_dist_x = dd;
    end
    return c;
  endfunction

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both
  function automatic int traffic_phase();
    return (cols_taken * 4) / total_cols;
  endfunction

  function automatic bit sender_idle();
    case (traffic_phase())
      1:       return $urandom_range(99) < 81;
      3:       return $urandom_range(99) < 24;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (traffic_phase())
      2:       return $urandom_range(99) < 81;
      3:       return $urandom_range(99) < 24;
      default: return 1'b0;
    endcase
  endfunction

  task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_slice(wall_slice_t got);
    wall_slice_t exp_s;
    if (slice_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %p", $time, got);
      mismatches++;
    end else begin
      exp_s = slice_q.pop_front();
      compare_field("perp_dist", exp_s.perp_dist, got.perp_dist);
      compare_field("line_height", exp_s.line_height, got.line_height);
      compare_field("draw_start", exp_s.draw_start, got.draw_start);
      compare_field("draw_end", exp_s.draw_end, got.draw_end);
      compare_field("tex_column", exp_s.tex_column, got.tex_column);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drive columns, record expectations, drive ready and check results
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      col_if.valid   <= 1'b0;
      slice_if.ready <= 1'b0;
    end else begin
      if (col_if.valid && col_if.ready) begin
        slice_q.push_back(cur_job.typed ? cur_job.slice : project_column(cur_job.col));
        cols_taken++;
      end
      if (!col_if.valid || col_if.ready) begin
        if (col_q.size() != 0 && !sender_idle()) begin
          cur_job = col_q.pop_front();
          col_if.hit_side     <= cur_job.col.hit_side;
          col_if.side_dist_x  <= cur_job.col.side_dist_x;
          col_if.side_dist_y  <= cur_job.col.side_dist_y;
          col_if.delta_dist_x <= cur_job.col.delta_dist_x;
          col_if.delta_dist_y <= cur_job.col.delta_dist_y;
          col_if.pos_x        <= cur_job.col.pos_x;
          col_if.pos_y        <= cur_job.col.pos_y;
          col_if.ray_dir_x    <= cur_job.col.ray_dir_x;
          col_if.ray_dir_y    <= cur_job.col.ray_dir_y;
          col_if.valid        <= 1'b1;
        end else begin
          col_if.valid <= 1'b0;
        end
      end
      if (slice_if.valid && slice_if.ready)
        check_slice('{slice_if.perp_dist, slice_if.line_height, slice_if.draw_start,
                      slice_if.draw_end, slice_if.tex_column});
      slice_if.ready <= !receiver_stall();
    end
  end

  initial begin
    column_job_t job;
    rst_ni              = 1'b0;
    col_if.valid        = 1'b0;
    col_if.hit_side     = 1'b0;
    col_if.side_dist_x  = '0;
    col_if.side_dist_y  = '0;
    col_if.delta_dist_x = '0;
    col_if.delta_dist_y = '0;
    col_if.pos_x        = '0;
    col_if.pos_y        = '0;
    col_if.ray_dir_x    = '0;
    col_if.ray_dir_y    = '0;
    slice_if.ready      = 1'b0;
    cols_taken          = 0;
    mismatches          = 0;
    cycles              = 0;
    foreach (DIRECTED_JOBS[i]) col_q.push_back(DIRECTED_JOBS[i]);
    for (int i = 0; i < RANDOM_COLS; i++) begin
      job.col   = random_column();
      job.typed = 1'b0;
      job.slice = NONE;
      col_q.push_back(job);
    end
    total_cols = col_q.size();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait until every column is taken and every result checked
    while (col_q.size() != 0 || col_if.valid || slice_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
